// File: rtl/frs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frs_pkg
// Shared types and constants for the Fenwick rank/select counter: operation
// codes, sequencer states and the fixed widths of counts and word fields.
// ----------------------------------------------------------------------------
package frs_pkg;

    // width of one partial count and of every sum (kept modulo 256)
    localparam int CNT_W = 8;
    // width of the position, rank and answer fields
    localparam int POS_W = 8;

    // operation codes carried by an input word
    typedef enum logic [1:0] {
        OP_UPDATE = 2'd0,
        OP_QUERY  = 2'd1,
        OP_SELECT = 2'd2,
        OP_NONE   = 2'd3
    } frs_op_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPD,
        ST_SUM,
        ST_DESC
    } frs_state_t;

endpackage

`default_nettype wire

// File: rtl/frs_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frs_ram
// Simple dual-port count memory: one write port, one read port, registered
// read data. Contents are undefined until written.
// ----------------------------------------------------------------------------
module frs_ram
    import frs_pkg::*;
#(
    parameter int DEPTH = 128,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [CNT_W-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [CNT_W-1:0] rdata
);

    logic [CNT_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: rtl/frs_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frs_seq
// Tree walk sequencer: clears the count memory after reset, then walks the
// Fenwick tree one node per cycle for update (read-modify-write upward),
// prefix sum (read downward) and select (total walk, then binary descent).
// ----------------------------------------------------------------------------
module frs_seq
    import frs_pkg::*;
#(
    parameter int SIZE = 128,
    parameter int IW   = $clog2(SIZE)
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    // command side
    input  wire logic             start,
    output logic                  busy,
    input  wire logic [1:0]       operation,
    input  wire logic [POS_W-1:0] position,
    input  wire logic [1:0]       delta,
    input  wire logic [POS_W-1:0] rank,
    // result side
    output logic                  done,
    output logic      [POS_W-1:0] answer,
    output logic                  miss,
    // count memory
    output logic                  mem_we,
    output logic      [IW-1:0]    mem_waddr,
    output logic      [CNT_W-1:0] mem_wdata,
    output logic      [IW-1:0]    mem_raddr,
    input  wire logic [CNT_W-1:0] mem_rdata
);

    // node numbers reach up to twice SIZE during an update walk
    localparam int NW  = IW + 2;
    // highest power of two not above SIZE, first step of the descent
    localparam int TOP = 2 ** ($clog2(SIZE + 1) - 1);

    localparam logic [NW-1:0] SIZE_N = NW'(SIZE);
    localparam logic [NW-1:0] TOP_N  = NW'(TOP);
    localparam logic [NW-1:0] ONE_N  = NW'(1);

    frs_state_t       state_reg,  state_next;
    frs_op_t          op_reg,     op_next;
    logic [NW-1:0]    node_reg,   node_next;
    logic [NW-1:0]    cur_reg,    cur_next;
    logic [NW-1:0]    step_reg,   step_next;
    logic [CNT_W-1:0] sum_reg,    sum_next;
    logic [CNT_W-1:0] left_reg,   left_next;
    logic [CNT_W-1:0] amt_reg,    amt_next;
    logic [POS_W-1:0] rank_reg,   rank_next;
    logic             valid_reg,  valid_next;
    logic [IW-1:0]    clr_reg,    clr_next;
    logic             done_reg,   done_next;
    logic [POS_W-1:0] answer_reg, answer_next;
    logic             miss_reg,   miss_next;

    logic [NW-1:0]    low_bit;

    // lowest set bit of the current node
    assign low_bit = node_reg & (~node_reg + ONE_N);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
            valid_reg <= valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        node_reg   <= node_next;
        cur_reg    <= cur_next;
        step_reg   <= step_next;
        sum_reg    <= sum_next;
        left_reg   <= left_next;
        amt_reg    <= amt_next;
        rank_reg   <= rank_next;
        answer_reg <= answer_next;
        miss_reg   <= miss_next;
    end

    // next state, memory control and result
    always_comb
    begin
        logic [NW-1:0]    nxt;
        logic [NW-1:0]    qpos;
        logic [CNT_W-1:0] s;
        logic [NW-1:0]    c;
        logic [CNT_W-1:0] l;
        logic [NW-1:0]    st;

        state_next  = state_reg;
        op_next     = op_reg;
        node_next   = node_reg;
        cur_next    = cur_reg;
        step_next   = step_reg;
        sum_next    = sum_reg;
        left_next   = left_reg;
        amt_next    = amt_reg;
        rank_next   = rank_reg;
        valid_next  = valid_reg;
        clr_next    = clr_reg;
        done_next   = 1'b0;
        answer_next = answer_reg;
        miss_next   = miss_reg;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = '0;
        mem_raddr   = '0;
        nxt         = '0;
        qpos        = '0;
        s           = '0;
        c           = '0;
        l           = '0;
        st          = '0;

        case (state_reg)
            // zero one entry per cycle after reset
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + IW'(1);
                if (clr_reg == IW'(SIZE - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            // take a command word and issue the first read, or answer at once without a walk
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next   = frs_op_t'(operation);
                    amt_next  = {{(CNT_W - 2){delta[1]}}, delta};
                    rank_next = rank;
                    sum_next  = '0;
                    case (frs_op_t'(operation))
                        OP_UPDATE:
                        begin
                            if (position == '0 || int'(position) > SIZE)
                            begin
                                done_next   = 1'b1;
                                answer_next = '0;
                                miss_next   = 1'b0;
                            end
                            else
                            begin
                                node_next  = NW'(position);
                                mem_raddr  = IW'(position - POS_W'(1));
                                state_next = ST_UPD;
                            end
                        end
                        OP_QUERY:
                        begin
                            qpos = (int'(position) > SIZE) ? SIZE_N : NW'(position);
                            if (position == '0)
                            begin
                                done_next   = 1'b1;
                                answer_next = '0;
                                miss_next   = 1'b0;
                            end
                            else
                            begin
                                node_next  = qpos;
                                mem_raddr  = IW'(qpos - ONE_N);
                                state_next = ST_SUM;
                            end
                        end
                        OP_SELECT:
                        begin
                            node_next  = SIZE_N;
                            mem_raddr  = IW'(SIZE - 1);
                            state_next = ST_SUM;
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            answer_next = '0;
                            miss_next   = 1'b0;
                        end
                    endcase
                end
            end

            // upward walk: write back this node, read the next one
            ST_UPD:
            begin
                mem_we    = 1'b1;
                mem_waddr = IW'(node_reg - ONE_N);
                mem_wdata = mem_rdata + amt_reg;
                nxt       = node_reg + low_bit;
                if (nxt <= SIZE_N)
                begin
                    node_next = nxt;
                    mem_raddr = IW'(nxt - ONE_N);
                end
                else
                begin
                    done_next   = 1'b1;
                    answer_next = '0;
                    miss_next   = 1'b0;
                    state_next  = ST_IDLE;
                end
            end

            // downward walk accumulating the prefix sum
            ST_SUM:
            begin
                s   = sum_reg + mem_rdata;
                nxt = node_reg - low_bit;
                if (nxt != '0)
                begin
                    sum_next  = s;
                    node_next = nxt;
                    mem_raddr = IW'(nxt - ONE_N);
                end
                else if (op_reg == OP_QUERY)
                begin
                    done_next   = 1'b1;
                    answer_next = POS_W'(s);
                    miss_next   = 1'b0;
                    state_next  = ST_IDLE;
                end
                else if (rank_reg == '0 || rank_reg > POS_W'(s))
                begin
                    done_next   = 1'b1;
                    answer_next = '0;
                    miss_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    cur_next   = '0;
                    step_next  = TOP_N;
                    left_next  = CNT_W'(rank_reg);
                    node_next  = TOP_N;
                    mem_raddr  = IW'(TOP - 1);
                    valid_next = 1'b1;
                    state_next = ST_DESC;
                end
            end

            // binary descent, one step per cycle
            ST_DESC:
            begin
                c = cur_reg;
                l = left_reg;
                if (valid_reg && mem_rdata < left_reg)
                begin
                    c = node_reg;
                    l = left_reg - mem_rdata;
                end
                st = step_reg >> 1;
                if (st == '0)
                begin
                    done_next  = 1'b1;
                    valid_next = 1'b0;
                    state_next = ST_IDLE;
                    if (c == SIZE_N)
                    begin
                        answer_next = '0;
                        miss_next   = 1'b1;
                    end
                    else
                    begin
                        answer_next = POS_W'(c + ONE_N);
                        miss_next   = 1'b0;
                    end
                end
                else
                begin
                    nxt        = c + st;
                    valid_next = (nxt <= SIZE_N);
                    mem_raddr  = IW'(nxt - ONE_N);
                    node_next  = nxt;
                    cur_next   = c;
                    left_next  = l;
                    step_next  = st;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign answer = answer_reg;
    assign miss   = miss_reg;

endmodule

`default_nettype wire

// File: rtl/fenwick_rank_select_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fenwick_rank_select_core
// Order-statistic counter over SIZE positions kept as a Fenwick tree of
// 8-bit partial counts in one synchronous memory.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low; every command
// gives exactly one result, shown for one cycle with done high, and the
// receiver must take it then. After reset the block is busy while it zeroes
// the count memory. The memory's single read port sets the pace: the walk
// reads one tree node at a time. An update or prefix query visits at most
// log2(SIZE)+1 nodes, so 8 for SIZE=128, and its result is registered from
// the last node; out-of-range updates, zero queries and the unused code
// answer at once without a walk. A select first sums the root path of SIZE
// (one node per set bit of SIZE) and then descends one level per cycle
// (log2 of the largest power of two within SIZE, plus one, levels). Counts
// and sums wrap modulo 256.
// ----------------------------------------------------------------------------
module fenwick_rank_select_core
    import frs_pkg::*;
#(
    parameter int SIZE = 128
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire logic [1:0]       operation,
    input  wire logic [POS_W-1:0] position,
    input  wire logic [1:0]       delta,
    input  wire logic [POS_W-1:0] rank,
    output logic                  done,
    output logic      [POS_W-1:0] answer,
    output logic                  miss
);

    localparam int IW = $clog2(SIZE);

    logic             mem_we;
    logic [IW-1:0]    mem_waddr;
    logic [CNT_W-1:0] mem_wdata;
    logic [IW-1:0]    mem_raddr;
    logic [CNT_W-1:0] mem_rdata;

    // tree walk sequencer
    frs_seq #(
        .SIZE (SIZE),
        .IW   (IW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .operation (operation),
        .position  (position),
        .delta     (delta),
        .rank      (rank),
        .done      (done),
        .answer    (answer),
        .miss      (miss),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // partial count memory
    frs_ram #(
        .DEPTH (SIZE),
        .AW    (IW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

`default_nettype wire

// File: rtl/frs_check.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frs_check
// Port-level checker for the Fenwick rank/select core, bound to the top.
// ----------------------------------------------------------------------------
module frs_check
    import frs_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire logic             done,
    input wire logic [POS_W-1:0] answer,
    input wire logic             miss
);

    // a result only follows a taken word or work in progress
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy || start))
        else $error("result word without a command");

    // the block is ready again when a result is shown
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("busy while showing a result");

    // busy only rises on a taken command once out of reset
    a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(busy) && $past(rst_n)) |-> $past(start))
        else $error("busy rose without start");

    // a missed select answers zero
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && miss) |-> (answer == '0))
        else $error("miss with nonzero answer");

endmodule

bind fenwick_rank_select_core frs_check u_frs_check (.*);

`default_nettype wire
